/* rtl/deadline_callout_scheduler_macros.svh */
// Assertion macros for the deadline callout scheduler.
// Included by the controller and datapath; needs nothing else.
`ifndef DEADLINE_CALLOUT_SCHEDULER_MACROS_SVH
`define DEADLINE_CALLOUT_SCHEDULER_MACROS_SVH
`ifndef SYNTH
`define DCS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DCS_ASSERT_ONEHOT(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) $onehot(sig)) else $error(msg);
`else
`define DCS_ASSERT(label, clk, rst_n, prop, msg)
`define DCS_ASSERT_ONEHOT(label, clk, rst_n, sig, msg)
`endif
`endif

/* rtl/dcs_pkg.sv */
// Types and codes shared by the deadline callout scheduler.
// No dependencies.
`timescale 1ns / 1ps
package dcs_pkg;
  localparam int unsigned ReqBits  = 3;
  localparam int unsigned SlotBits = 4;
  localparam int unsigned ArgBits  = 48;
  localparam int unsigned PerBits  = 32;
  localparam int unsigned NowBits  = 48;
  localparam int unsigned MaxFire  = 16;

  localparam logic [2:0] ReqTick   = 3'd0;
  localparam logic [2:0] ReqSchRel = 3'd1;
  localparam logic [2:0] ReqSchAbs = 3'd2;
  localparam logic [2:0] ReqCancel = 3'd3;
  localparam logic [2:0] ReqPush   = 3'd4;
  localparam logic [2:0] ReqQuery  = 3'd5;

  localparam logic [1:0] KindAck   = 2'd0;
  localparam logic [1:0] KindFired = 2'd1;
  localparam logic [1:0] KindQuery = 2'd2;

  typedef struct packed {
    logic [ReqBits-1:0]  req_type;
    logic [SlotBits-1:0] slot;
    logic [ArgBits-1:0]  time_arg;
    logic [PerBits-1:0]  repeat_period;
  } req_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SlotBits-1:0] out_slot;
    logic                is_armed;
    logic [NowBits-1:0]  now_us;
    logic                last;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // latch the request beat
    logic exec;      // apply a non-tick request
    logic adv;       // advance the clock
    logic mark;      // snapshot the due set
    logic scan_clr;  // start a minimum search
    logic scan_step; // compare one slot
    logic fire;      // fire the search winner
    logic emit_ack;  // present the acknowledge or query beat
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_tick;
    logic scan_end;
    logic found;
    logic fire_cap;
  } sts_t;
endpackage

/* rtl/dcs_datapath.sv */
// Datapath of the deadline callout scheduler: clock, slot table, due scan.
// Depends on dcs_pkg and the macros header.
`timescale 1ns / 1ps
`include "deadline_callout_scheduler_macros.svh"
module dcs_datapath #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dcs_pkg::req_t req_i,
  input  dcs_pkg::cmd_t cmd_i,
  output dcs_pkg::sts_t sts_o,
  output dcs_pkg::rsp_t rsp_o,
  output logic          rsp_set_o
);
  import dcs_pkg::*;

  localparam int unsigned IdxBits = $clog2(NUM_SLOTS);
  localparam int unsigned CntBits = $clog2(NUM_SLOTS + 1);
  localparam int unsigned FireBits = $clog2(MaxFire + 1);
  localparam logic [TIME_BITS-1:0] TMax = '1;

  req_t                 req_q;
  logic [TIME_BITS-1:0] clock_q;
  logic [TIME_BITS-1:0] dl_q [NUM_SLOTS];
  logic [PerBits-1:0]   per_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] armed_q;
  logic [PerBits-1:0]   stamp_q [NUM_SLOTS];
  logic [PerBits-1:0]   ins_q;
  logic [NUM_SLOTS-1:0] due_q;
  logic [CntBits-1:0]   scan_q;
  logic                 found_q;
  logic [IdxBits-1:0]   best_q;
  logic [FireBits-1:0]  nfire_q;

  // Saturating add of two time-width operands.
  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TMax : s[TIME_BITS-1:0];
  endfunction

  logic                 slot_ok;
  logic [IdxBits-1:0]   sidx;
  logic [TIME_BITS-1:0] targ;
  logic [IdxBits-1:0]   cidx;
  logic                 better;
  logic [TIME_BITS-1:0] clock_nx;

  always_comb begin
    slot_ok = {{(32-SlotBits){1'b0}}, req_q.slot} < NUM_SLOTS;
    sidx = IdxBits'(req_q.slot);
    if (TIME_BITS >= ArgBits) begin
      targ = TIME_BITS'(req_q.time_arg);
    end else begin
      targ = (req_q.time_arg > ArgBits'(TMax)) ? TMax : TIME_BITS'(req_q.time_arg);
    end
    cidx = scan_q[IdxBits-1:0];
    better = !found_q || (dl_q[cidx] < dl_q[best_q]) ||
             ((dl_q[cidx] == dl_q[best_q]) && (stamp_q[cidx] < stamp_q[best_q]));
    clock_nx = sat_add(clock_q, TIME_BITS'(1));
  end

  assign sts_o.is_tick  = (req_q.req_type == ReqTick);
  assign sts_o.scan_end = (scan_q == CntBits'(NUM_SLOTS));
  assign sts_o.found    = found_q;
  assign sts_o.fire_cap = (nfire_q == FireBits'(MaxFire));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= '0;
      armed_q <= '0;
      ins_q   <= '0;
      due_q   <= '0;
      scan_q  <= '0;
      found_q <= 1'b0;
      best_q  <= '0;
      nfire_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        dl_q[i]    <= '0;
        per_q[i]   <= '0;
        stamp_q[i] <= '0;
      end
    end else begin
      if (cmd_i.exec && slot_ok) begin
        unique case (req_q.req_type) inside
          ReqSchRel, ReqSchAbs: begin
            if (req_q.req_type == ReqSchRel) begin
              dl_q[sidx] <= sat_add(clock_q, targ);
            end else begin
              dl_q[sidx] <= (targ < clock_q) ? clock_q : targ;
            end
            per_q[sidx]   <= req_q.repeat_period;
            armed_q[sidx] <= 1'b1;
            stamp_q[sidx] <= ins_q;
            ins_q         <= ins_q + 1'b1;
          end
          ReqCancel: begin
            armed_q[sidx] <= 1'b0;
            dl_q[sidx]    <= '0;
            per_q[sidx]   <= '0;
          end
          ReqPush: begin
            if (armed_q[sidx]) begin
              dl_q[sidx]    <= sat_add(dl_q[sidx], targ);
              stamp_q[sidx] <= ins_q;
              ins_q         <= ins_q + 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.adv) begin
        clock_q <= clock_nx;
        nfire_q <= '0;
      end
      if (cmd_i.mark) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          due_q[i] <= armed_q[i] && (dl_q[i] <= clock_q);
        end
      end
      if (cmd_i.scan_clr) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        scan_q <= scan_q + 1'b1;
        if (due_q[cidx] && better) begin
          best_q  <= cidx;
          found_q <= 1'b1;
        end
      end
      if (cmd_i.fire) begin
        due_q[best_q] <= 1'b0;
        nfire_q <= nfire_q + 1'b1;
        if (per_q[best_q] != '0) begin
          dl_q[best_q]    <= sat_add(dl_q[best_q], TIME_BITS'(per_q[best_q]));
          stamp_q[best_q] <= ins_q;
          ins_q           <= ins_q + 1'b1;
        end else begin
          armed_q[best_q] <= 1'b0;
          dl_q[best_q]    <= '0;
        end
      end
    end
  end

  // Result beat built from state as it stands after the step.
  logic [NowBits-1:0]   now_w;
  logic [NUM_SLOTS-1:0] due_rest;
  logic                 fire_last;
  always_comb begin
    if (TIME_BITS >= NowBits) begin
      now_w = clock_q[NowBits-1:0];
    end else begin
      now_w = NowBits'(clock_q);
    end
    // A fired beat is the final one when no other slot is still due or the
    // per-tick firing limit is reached with it.
    due_rest = due_q;
    due_rest[best_q] = 1'b0;
    fire_last = (due_rest == '0) || (nfire_q == FireBits'(MaxFire - 1));
    rsp_set_o = cmd_i.emit_ack || cmd_i.fire;
    rsp_o = '0;
    rsp_o.now_us = now_w;
    if (cmd_i.fire) begin
      rsp_o.kind     = KindFired;
      rsp_o.out_slot = SlotBits'(best_q);
      rsp_o.is_armed = (per_q[best_q] != '0);
      rsp_o.last     = fire_last;
    end else if (sts_o.is_tick) begin
      rsp_o.kind = KindAck;
      rsp_o.last = 1'b1;
    end else begin
      rsp_o.kind     = (req_q.req_type == ReqQuery) ? KindQuery : KindAck;
      rsp_o.out_slot = req_q.slot;
      rsp_o.is_armed = slot_ok && armed_q[sidx];
      rsp_o.last     = 1'b1;
    end
  end

  `DCS_ASSERT(a_fire_due, clk_i, rst_ni, cmd_i.fire |-> (found_q && due_q[best_q]), "fire not due")
  `DCS_ASSERT(a_fire_armed, clk_i, rst_ni, cmd_i.fire |-> armed_q[best_q], "fire of idle slot")
  `DCS_ASSERT(a_cap, clk_i, rst_ni, nfire_q <= FireBits'(MaxFire), "fire count past limit")
endmodule

/* rtl/dcs_ctrl.sv */
// Controller of the deadline callout scheduler: sequences one request.
// Depends on dcs_pkg and the macros header.
`timescale 1ns / 1ps
`include "deadline_callout_scheduler_macros.svh"
module dcs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  logic          out_free_i,
  input  dcs_pkg::sts_t sts_i,
  output dcs_pkg::cmd_t cmd_o
);
  import dcs_pkg::*;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StDec  = 7'b0000010,
    StMark = 7'b0000100,
    StScan = 7'b0001000,
    StFire = 7'b0010000,
    StAck  = 7'b0100000,
    StLast = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   fired_q, fired_d;

  always_comb begin
    state_d = state_q;
    fired_d = fired_q;
    cmd_o = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StDec;
        end
      end
      StDec: begin
        if (sts_i.is_tick) begin
          cmd_o.adv = 1'b1;
          fired_d = 1'b0;
          state_d = StMark;
        end else begin
          cmd_o.exec = 1'b1;
          state_d = StAck;
        end
      end
      StMark: begin
        cmd_o.mark = 1'b1;
        cmd_o.scan_clr = 1'b1;
        state_d = StScan;
      end
      StScan: begin
        if (!sts_i.scan_end) begin
          cmd_o.scan_step = 1'b1;
        end else if (sts_i.found && !sts_i.fire_cap) begin
          state_d = StFire;
        end else if (fired_q) begin
          state_d = StLast;
        end else begin
          state_d = StAck;
        end
      end
      StFire: begin
        if (out_free_i) begin
          cmd_o.fire = 1'b1;
          cmd_o.scan_clr = 1'b1;
          fired_d = 1'b1;
          state_d = StScan;
        end
      end
      StAck: begin
        if (out_free_i) begin
          cmd_o.emit_ack = 1'b1;
          state_d = StIdle;
        end
      end
      StLast: begin
        if (out_free_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fired_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fired_q <= fired_d;
    end
  end

  `DCS_ASSERT_ONEHOT(a_onehot, clk_i, rst_ni, state_q, "state not one-hot")
  `DCS_ASSERT(a_ready_idle, clk_i, rst_ni, req_ready_o |-> (state_q == StIdle), "ready outside idle")
  `DCS_ASSERT(a_fire_wait, clk_i, rst_ni, (cmd_o.fire || cmd_o.emit_ack) |-> out_free_i, "beat made while output full")
endmodule

/* rtl/dcs_out_reg.sv */
// Output register of the deadline callout scheduler; holds one result beat.
// Depends on dcs_pkg.
`timescale 1ns / 1ps
module dcs_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          set_i,
  input  dcs_pkg::rsp_t data_i,
  output logic          free_o,
  output logic          valid_o,
  input  logic          ready_i,
  output dcs_pkg::rsp_t data_o
);
  import dcs_pkg::*;

  logic valid_q;
  rsp_t data_q;

  // A new beat may enter in the same cycle that the held one leaves.
  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  always_comb begin
    data_o = data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (set_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_i) begin
      data_q <= data_i;
    end
  end
endmodule

/* rtl/deadline_callout_scheduler.sv */
// Top level of the deadline callout scheduler.
// Depends on dcs_pkg, dcs_ctrl, dcs_datapath and dcs_out_reg.
// Usage:
//   Requests come in as req_t beats on req_valid_i/req_ready_o; results leave
//   as rsp_t beats on rsp_valid_o/rsp_ready_i, the final one of a request
//   carrying last. One request is handled at a time.
//   A non-tick request is latched, applied and then gives its single beat,
//   after which the controller returns to idle for the next request.
//   A tick advances the clock, snapshots the due slots and then finds each
//   slot to fire with a serial search, one slot per cycle, then fires the
//   winner, up to MaxFire per tick; a last search after the final fire ends the tick.
//   A tick that fires nothing gives a single acknowledge beat.
//   Reset clears the clock, every slot and the insertion counter at once.
//   When the receiver stalls, the held beat stays in the output register
//   and the sequence pauses before its next beat or its end until it leaves.
`timescale 1ns / 1ps
module deadline_callout_scheduler #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  dcs_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output dcs_pkg::rsp_t rsp_o
);
  import dcs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp_d;
  logic rsp_set;
  logic out_free;

  dcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .out_free_i  (out_free),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dcs_datapath #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .rsp_o     (rsp_d),
    .rsp_set_o (rsp_set)
  );

  dcs_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .set_i   (rsp_set),
    .data_i  (rsp_d),
    .free_o  (out_free),
    .valid_o (rsp_valid_o),
    .ready_i (rsp_ready_i),
    .data_o  (rsp_o)
  );
endmodule
